// ===== sv/psu_pkg.sv =====
// particle store update: shared types, codes and saturation helpers
// no dependencies
`default_nettype none
package psu_pkg;

  typedef logic signed [31:0] pos_t;
  typedef logic [30:0]        ufix_t;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_RESET = 2'd2;

  // motion modes
  localparam logic [2:0] MODE_FALL   = 3'd0;
  localparam logic [2:0] MODE_RISE   = 3'd1;
  localparam logic [2:0] MODE_NORM   = 3'd2;
  localparam logic [2:0] MODE_RADIAL = 3'd3;
  localparam logic [2:0] MODE_RAW    = 3'd4;
  localparam logic [2:0] MODE_AGE    = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_COUNT   = 3'd0;
  localparam logic [2:0] CFG_LOOP    = 3'd1;
  localparam logic [2:0] CFG_PIVOT_X = 3'd2;
  localparam logic [2:0] CFG_PIVOT_Y = 3'd3;
  localparam logic [2:0] CFG_PIVOT_Z = 3'd4;

  localparam logic [6:0] COUNT_RESET = 7'd64;

  // per particle words held in the two memories
  typedef struct packed {
    pos_t  x;
    pos_t  y;
    pos_t  z;
    ufix_t elapsed;
  } state_word_t;

  typedef struct packed {
    pos_t  sx;
    pos_t  sy;
    pos_t  sz;
    ufix_t speed;
    ufix_t limit;
  } const_word_t;

  // clamp a 33 bit sum to the position range
  function automatic pos_t sat_pos(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // product >> 16, clamped to 2^31 - 1
  function automatic ufix_t mul_sat(input logic [62:0] prod);
    if (|prod[62:47]) begin
      return '1;
    end
    return prod[46:16];
  endfunction

endpackage
`default_nettype wire

// ===== sv/psu_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/psu_norm.sv =====
// vector normalizer: squares on one multiplier, bit serial root, three serial dividers
// no dependencies
`default_nettype none
module psu_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] vin_x,
  input  logic signed [32:0] vin_y,
  input  logic signed [32:0] vin_z,
  output logic               done,
  output logic signed [17:0] unit_x,
  output logic signed [17:0] unit_y,
  output logic signed [17:0] unit_z
);

  typedef enum logic [1:0] {N_IDLE, N_SQ, N_ROOT, N_DIV} nstate_t;

  nstate_t            st_r;
  logic [4:0]         cnt_r;
  logic [30:0]        m_r [3];
  logic               neg_r [3];
  logic [61:0]        sq_r;
  logic               sq_vld_r;
  logic [63:0]        sum_r;
  logic [63:0]        rad_r;
  logic [31:0]        root_r;
  logic [33:0]        rrem_r;
  logic [31:0]        rem_r [3];
  logic [16:0]        tl_r [3];
  logic [16:0]        q_r [3];
  logic               done_r;
  logic signed [17:0] unit_r [3];

  logic signed [32:0] vin [3];
  logic [32:0]        amag [3];
  logic [30:0]        m_in [3];
  logic               big2, big1;
  logic [30:0]        sq_src;
  logic [35:0]        rt_sh;
  logic [35:0]        rt_trial;
  logic [32:0]        dv_sh [3];
  logic               dv_ge [3];
  logic [16:0]        q_nxt [3];

  assign vin[0] = vin_x;
  assign vin[1] = vin_y;
  assign vin[2] = vin_z;

  // common prescale so every magnitude is below 2^31
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      amag[k] = vin[k][32] ? 33'(-vin[k]) : 33'(vin[k]);
    end
    big2 = amag[0][32] | amag[1][32] | amag[2][32];
    big1 = amag[0][31] | amag[1][31] | amag[2][31];
    for (int k = 0; k < 3; k++) begin
      if (big2) begin
        m_in[k] = amag[k][32:2];
      end else if (big1) begin
        m_in[k] = amag[k][31:1];
      end else begin
        m_in[k] = amag[k][30:0];
      end
    end
  end

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_src = m_r[0];
      2'd1:    sq_src = m_r[1];
      2'd2:    sq_src = m_r[2];
      default: sq_src = '0;
    endcase
  end

  // one root digit a cycle
  assign rt_sh    = {rrem_r, rad_r[63:62]};
  assign rt_trial = {2'b00, root_r, 2'b01};

  // one quotient bit a cycle per component
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_sh[k] = {rem_r[k], tl_r[k][16]};
      dv_ge[k] = dv_sh[k] >= {1'b0, root_r};
      q_nxt[k] = {q_r[k][15:0], dv_ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= N_IDLE;
      cnt_r    <= '0;
      sq_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      case (st_r)
        N_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            for (int k = 0; k < 3; k++) begin
              m_r[k]   <= m_in[k];
              neg_r[k] <= vin[k][32];
            end
            cnt_r    <= '0;
            sum_r    <= '0;
            sq_vld_r <= 1'b0;
            st_r     <= N_SQ;
          end
        end
        N_SQ: begin
          sq_r     <= 62'(sq_src) * 62'(sq_src);
          sq_vld_r <= (cnt_r != 5'd3);
          if (sq_vld_r) begin
            sum_r <= sum_r + 64'(sq_r);
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd3) begin
            rad_r  <= sum_r + 64'(sq_r);
            root_r <= '0;
            rrem_r <= '0;
            cnt_r  <= '0;
            st_r   <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (rt_sh >= rt_trial) begin
            rrem_r <= 34'(rt_sh - rt_trial);
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rrem_r <= rt_sh[33:0];
            root_r <= {root_r[30:0], 1'b0};
          end
          rad_r <= {rad_r[61:0], 2'b00};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            for (int k = 0; k < 3; k++) begin
              rem_r[k] <= {2'b00, m_r[k][30:1]};
              tl_r[k]  <= {m_r[k][0], 16'h0000};
              q_r[k]   <= '0;
            end
            cnt_r <= '0;
            st_r  <= N_DIV;
          end
        end
        N_DIV: begin
          for (int k = 0; k < 3; k++) begin
            rem_r[k] <= dv_ge[k] ? 32'(dv_sh[k] - {1'b0, root_r}) : dv_sh[k][31:0];
            tl_r[k]  <= {tl_r[k][15:0], 1'b0};
            q_r[k]   <= q_nxt[k];
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd16) begin
            for (int k = 0; k < 3; k++) begin
              if (root_r == '0) begin
                unit_r[k] <= '0;
              end else if (neg_r[k]) begin
                unit_r[k] <= -$signed({1'b0, q_nxt[k]});
              end else begin
                unit_r[k] <= $signed({1'b0, q_nxt[k]});
              end
            end
            done_r <= 1'b1;
            cnt_r  <= '0;
            st_r   <= N_IDLE;
          end
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign unit_x = unit_r[0];
  assign unit_y = unit_r[1];
  assign unit_z = unit_r[2];

endmodule
`default_nettype wire

// ===== sv/particle_store_update.sv =====
// particle store update top level: sequencer, step multiplier, two particle memories
// depends on psu_pkg, psu_ram, psu_norm
// a load writes both memories; a reset-to-spawn reads, then writes, each particle;
//   a tick per particle ages only, moves along y (fall, rise), or adds a multiply pass
//   per axis (raw, normalized, radial; radial waits on the normalizer's 32 step root
//   and 17 step divide); normalized ticks normalize once before the first particle
// one word at a time; the result register lets the sequencer run ahead by one word
// synchronous active-low reset clears control state; memories are not cleared
`default_nettype none
module particle_store_update #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // request words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_particle_index,
  input  logic [31:0] in_vector_x,
  input  logic [31:0] in_vector_y,
  input  logic [31:0] in_vector_z,
  input  logic [30:0] in_particle_speed,
  input  logic [30:0] in_life_limit,
  input  logic [30:0] in_time_step,
  input  logic [2:0]  in_motion_mode,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_index,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [30:0] out_elapsed_life,
  output logic        out_expired,
  output logic        out_last
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int SW = $bits(psu_pkg::state_word_t);
  localparam int KW = $bits(psu_pkg::const_word_t);

  typedef enum logic [3:0] {
    S_IDLE, S_NRM_WAIT, S_RST_RD, S_RST_WR, S_RD, S_DAT, S_STEP,
    S_DIR, S_MUL, S_ADD, S_FR, S_AGE
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       i_r;
  logic [CW-1:0]       n_r;
  logic [1:0]          k_r;
  psu_pkg::ufix_t      dt_r;
  logic [2:0]          mode_r;
  psu_pkg::pos_t       dir_r [3];
  psu_pkg::pos_t       p_r [3];
  psu_pkg::ufix_t      el_r;
  psu_pkg::ufix_t      step_r;
  logic [62:0]         prod_r;

  // configuration registers
  logic [6:0]          count_r;
  logic                loop_r;
  psu_pkg::pos_t       piv_r [3];

  // result register
  logic                out_valid_r;
  logic [5:0]          out_index_r;
  psu_pkg::pos_t       out_pos_r [3];
  psu_pkg::ufix_t      out_el_r;
  logic                out_exp_r;
  logic                out_last_r;

  // memory ports
  logic                st_we, cn_we, mem_re;
  logic [AW-1:0]       st_waddr, mem_raddr, ld_addr;
  psu_pkg::state_word_t st_wdata, st_dout;
  psu_pkg::const_word_t cn_wdata, cn_dout;
  logic [SW-1:0]       st_rbits;
  logic [KW-1:0]       cn_rbits;

  // normalizer
  logic                nrm_start, nrm_done;
  logic signed [32:0]  nrm_in [3];
  logic signed [17:0]  nrm_ux, nrm_uy, nrm_uz;

  // datapath helpers
  logic                in_acc;
  logic [CW-1:0]       n_in;
  logic [2:0]          mode_in;
  logic                ld_ok;
  logic [31:0]         mul_a;
  logic [30:0]         mul_b;
  psu_pkg::pos_t       dsel;
  logic [31:0]         dmag;
  psu_pkg::ufix_t      smag;
  logic signed [32:0]  scaled;
  logic [31:0]         el_sum;
  psu_pkg::ufix_t      el_new;
  logic                hit, respawn, fr_mode;
  logic                age_go, last_one;
  psu_pkg::pos_t       fin [3];

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // active particle count, limited to the store depth
  assign n_in = (int'(count_r) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(count_r);
  // modes six and seven only age
  assign mode_in = (in_motion_mode > psu_pkg::MODE_AGE) ? psu_pkg::MODE_AGE : in_motion_mode;
  assign ld_ok   = int'(in_particle_index) < MAX_PARTICLES;
  assign ld_addr = AW'(in_particle_index);

  // memory access
  assign mem_re    = (state_r == S_RST_RD) || (state_r == S_RD);
  assign mem_raddr = AW'(i_r);
  assign cn_we     = in_acc && (in_req_type == psu_pkg::REQ_LOAD) && ld_ok;
  assign cn_wdata  = '{sx: in_vector_x, sy: in_vector_y, sz: in_vector_z,
                       speed: in_particle_speed, limit: in_life_limit};
  assign st_dout   = psu_pkg::state_word_t'(st_rbits);
  assign cn_dout   = psu_pkg::const_word_t'(cn_rbits);

  // shared 32x31 multiplier: speed * dt, then |dir| * step per axis
  always_comb begin
    dsel = dir_r[0];
    case (k_r)
      2'd0:    dsel = dir_r[0];
      2'd1:    dsel = dir_r[1];
      2'd2:    dsel = dir_r[2];
      default: dsel = dir_r[0];
    endcase
    dmag = dsel[31] ? 32'(-dsel) : 32'(dsel);
    if (state_r == S_DAT) begin
      mul_a = {1'b0, cn_dout.speed};
      mul_b = dt_r;
    end else begin
      mul_a = dmag;
      mul_b = step_r;
    end
  end

  // signed displacement of the current axis
  assign smag   = psu_pkg::mul_sat(prod_r);
  assign scaled = dsel[31] ? -$signed({2'b00, smag}) : $signed({2'b00, smag});

  // aging and respawn
  assign el_sum   = {1'b0, el_r} + {1'b0, dt_r};
  assign el_new   = el_sum[31] ? '1 : el_sum[30:0];
  assign hit      = cn_dout.limit <= el_new;
  assign respawn  = hit && loop_r;
  assign fr_mode  = (mode_r == psu_pkg::MODE_FALL) || (mode_r == psu_pkg::MODE_RISE);
  assign age_go   = (state_r == S_AGE) && (!out_valid_r || out_ready);
  assign last_one = (i_r + CW'(1)) == n_r;

  always_comb begin
    fin[0] = p_r[0];
    fin[1] = p_r[1];
    fin[2] = p_r[2];
    if (respawn) begin
      fin[1] = cn_dout.sy;
      if (!fr_mode) begin
        fin[0] = cn_dout.sx;
        fin[2] = cn_dout.sz;
      end
    end
  end

  // state memory writes: load, reset to spawn, tick write-back
  always_comb begin
    st_we    = 1'b0;
    st_waddr = AW'(i_r);
    st_wdata = '{x: fin[0], y: fin[1], z: fin[2], elapsed: respawn ? '0 : el_new};
    if (cn_we) begin
      st_we    = 1'b1;
      st_waddr = ld_addr;
      st_wdata = '{x: in_vector_x, y: in_vector_y, z: in_vector_z, elapsed: '0};
    end else if (state_r == S_RST_WR) begin
      st_we    = 1'b1;
      st_wdata = '{x: cn_dout.sx, y: cn_dout.sy, z: cn_dout.sz, elapsed: '0};
    end else if (age_go) begin
      st_we = 1'b1;
    end
  end

  // normalizer feeds: tick direction once, or particle minus pivot
  assign nrm_start = (in_acc && (in_req_type == psu_pkg::REQ_TICK) && (n_in != '0) &&
                      (mode_in == psu_pkg::MODE_NORM)) ||
                     ((state_r == S_STEP) && (mode_r == psu_pkg::MODE_RADIAL));
  always_comb begin
    if (state_r == S_IDLE) begin
      nrm_in[0] = 33'(signed'(in_vector_x));
      nrm_in[1] = 33'(signed'(in_vector_y));
      nrm_in[2] = 33'(signed'(in_vector_z));
    end else begin
      for (int k = 0; k < 3; k++) begin
        nrm_in[k] = 33'(p_r[k]) - 33'(piv_r[k]);
      end
    end
  end

  psu_ram #(.WIDTH(SW), .DEPTH(MAX_PARTICLES)) u_state_mem (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (st_rbits)
  );

  psu_ram #(.WIDTH(KW), .DEPTH(MAX_PARTICLES)) u_const_mem (
    .clk   (clk),
    .we    (cn_we),
    .waddr (ld_addr),
    .wdata (cn_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (cn_rbits)
  );

  psu_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (nrm_start),
    .vin_x  (nrm_in[0]),
    .vin_y  (nrm_in[1]),
    .vin_z  (nrm_in[2]),
    .done   (nrm_done),
    .unit_x (nrm_ux),
    .unit_y (nrm_uy),
    .unit_z (nrm_uz)
  );

  // sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      count_r     <= psu_pkg::COUNT_RESET;
      loop_r      <= 1'b0;
      piv_r[0]    <= '0;
      piv_r[1]    <= '0;
      piv_r[2]    <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          psu_pkg::CFG_COUNT:   count_r  <= cfg_wdata[6:0];
          psu_pkg::CFG_LOOP:    loop_r   <= cfg_wdata[0];
          psu_pkg::CFG_PIVOT_X: piv_r[0] <= cfg_wdata;
          psu_pkg::CFG_PIVOT_Y: piv_r[1] <= cfg_wdata;
          psu_pkg::CFG_PIVOT_Z: piv_r[2] <= cfg_wdata;
          default: ;
        endcase
      end

      // taken word clears the register unless a new one replaces it
      if (out_valid_r && out_ready && !age_go) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            i_r    <= '0;
            n_r    <= n_in;
            dt_r   <= in_time_step;
            mode_r <= mode_in;
            dir_r[0] <= in_vector_x;
            dir_r[1] <= in_vector_y;
            dir_r[2] <= in_vector_z;
            if (n_in != '0) begin
              case (in_req_type)
                psu_pkg::REQ_RESET: state_r <= S_RST_RD;
                psu_pkg::REQ_TICK:
                  state_r <= (mode_in == psu_pkg::MODE_NORM) ? S_NRM_WAIT : S_RD;
                default: state_r <= S_IDLE;
              endcase
            end
          end
        end
        S_NRM_WAIT: begin
          if (nrm_done) begin
            dir_r[0] <= 32'(nrm_ux);
            dir_r[1] <= 32'(nrm_uy);
            dir_r[2] <= 32'(nrm_uz);
            state_r  <= S_RD;
          end
        end
        S_RST_RD: state_r <= S_RST_WR;
        S_RST_WR: begin
          i_r     <= i_r + CW'(1);
          state_r <= last_one ? S_IDLE : S_RST_RD;
        end
        S_RD: state_r <= S_DAT;
        S_DAT: begin
          p_r[0]  <= st_dout.x;
          p_r[1]  <= st_dout.y;
          p_r[2]  <= st_dout.z;
          el_r    <= st_dout.elapsed;
          prod_r  <= 63'(mul_a) * 63'(mul_b);
          state_r <= S_STEP;
        end
        S_STEP: begin
          step_r <= psu_pkg::mul_sat(prod_r);
          k_r    <= '0;
          case (mode_r)
            psu_pkg::MODE_FALL,
            psu_pkg::MODE_RISE:   state_r <= S_FR;
            psu_pkg::MODE_NORM,
            psu_pkg::MODE_RAW:    state_r <= S_MUL;
            psu_pkg::MODE_RADIAL: state_r <= S_DIR;
            default:              state_r <= S_AGE;
          endcase
        end
        S_DIR: begin
          if (nrm_done) begin
            dir_r[0] <= 32'(nrm_ux);
            dir_r[1] <= 32'(nrm_uy);
            dir_r[2] <= 32'(nrm_uz);
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= 63'(mul_a) * 63'(mul_b);
          state_r <= S_ADD;
        end
        S_ADD: begin
          // one axis per pass: add the clamped displacement
          case (k_r)
            2'd0:    p_r[0] <= psu_pkg::sat_pos(33'(p_r[0]) + scaled);
            2'd1:    p_r[1] <= psu_pkg::sat_pos(33'(p_r[1]) + scaled);
            default: p_r[2] <= psu_pkg::sat_pos(33'(p_r[2]) + scaled);
          endcase
          k_r     <= k_r + 2'd1;
          state_r <= (k_r == 2'd2) ? S_AGE : S_MUL;
        end
        S_FR: begin
          if (mode_r == psu_pkg::MODE_FALL) begin
            p_r[1] <= psu_pkg::sat_pos(33'(p_r[1]) - $signed({2'b00, step_r}));
          end else begin
            p_r[1] <= psu_pkg::sat_pos(33'(p_r[1]) + $signed({2'b00, step_r}));
          end
          state_r <= S_AGE;
        end
        S_AGE: begin
          // hold here while the previous word is still unclaimed
          if (age_go) begin
            out_valid_r  <= 1'b1;
            out_index_r  <= 6'(i_r);
            out_pos_r[0] <= fin[0];
            out_pos_r[1] <= fin[1];
            out_pos_r[2] <= fin[2];
            out_el_r     <= respawn ? '0 : el_new;
            out_exp_r    <= hit && !loop_r;
            out_last_r   <= last_one;
            i_r          <= i_r + CW'(1);
            state_r      <= last_one ? S_IDLE : S_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_index        = out_index_r;
  assign out_pos_x        = out_pos_r[0];
  assign out_pos_y        = out_pos_r[1];
  assign out_pos_z        = out_pos_r[2];
  assign out_elapsed_life = out_el_r;
  assign out_expired      = out_exp_r;
  assign out_last         = out_last_r;

  // particle counter stays inside the active range while a walk is running
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_DAT || state_r == S_STEP || state_r == S_AGE ||
     state_r == S_RST_RD || state_r == S_RST_WR) |-> (i_r < n_r))
    else $error("particle counter beyond active count");

  // normalizer only finishes while the sequencer waits for it
  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    nrm_done |-> (state_r == S_NRM_WAIT || state_r == S_DIR))
    else $error("normalizer finished outside a wait state");

  // a new word is loaded only when the last one was taken or absent
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_index_r)))
    else $error("pending result word overwritten");

  // last flag marks the final active particle
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AGE && age_go) |=> (out_last_r == (i_r == n_r)))
    else $error("last flag does not match particle count");

endmodule
`default_nettype wire

// ===== sim/particle_store_update_tb.sv =====
// particle store update testbench: directed table, then random phases checked against a
// fixed-point predictor of the particle store; depends on psu_pkg and particle_store_update
`timescale 1ns / 1ps
`default_nettype none
module particle_store_update_tb;

  localparam int     N_PART     = 64;
  localparam longint POS_MAX    = 64'sd2147483647;
  localparam longint POS_MIN    = -64'sd2147483648;
  localparam longint unsigned ELAPSED_TOP = 64'h7FFF_FFFF;
  localparam int     STALL_LIMIT = 3000;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     PHASE_WORDS = 40;

  // one request word as driven on the input channel
  typedef struct {
    logic [1:0]  req;
    logic [5:0]  idx;
    logic [31:0] vx, vy, vz;
    logic [30:0] spd, lim, dt;
    logic [2:0]  mode;
  } req_word_t;

  // one result word
  typedef struct {
    logic [5:0]  idx;
    logic [31:0] x, y, z;
    logic [30:0] el;
    logic        expired;
    logic        last;
  } particle_report_t;

  // directed table row; typed rows carry a hand-written single-particle result
  typedef struct {
    req_word_t        w;
    bit               typed;
    particle_report_t e;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = psu_pkg::CFG_COUNT;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = psu_pkg::REQ_LOAD;
  logic [5:0]  in_particle_index = '0;
  logic [31:0] in_vector_x = '0, in_vector_y = '0, in_vector_z = '0;
  logic [30:0] in_particle_speed = '0, in_life_limit = '0, in_time_step = '0;
  logic [2:0]  in_motion_mode = psu_pkg::MODE_FALL;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_index;
  logic [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic [30:0] out_elapsed_life;
  logic        out_expired, out_last;

  always #5 clk = ~clk;

  particle_store_update dut (.*);

  // predictor copy of the particle store and the registers
  longint          cur_pos[N_PART][3];
  longint          spawn_pos[N_PART][3];
  longint unsigned speed_of[N_PART];
  longint unsigned limit_of[N_PART];
  longint unsigned elapsed_of[N_PART];
  int unsigned     count_reg = 64;
  bit              loop_reg = 1'b0;
  longint          pivot_reg[3] = '{0, 0, 0};

  particle_report_t pending_reports[$];

  int  errors = 0;
  int  reports_seen = 0;
  int  words_sent = 0;
  int  ticks_sent = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;      // final stretch: no idling on either side
  int  out_stall_left = 0;

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // a * b >> 16, clamped to the positive position range
  function automatic longint unsigned step_product(longint unsigned a, longint unsigned b);
    longint unsigned p;
    p = (a * b) >> 16;
    return p > longint'(POS_MAX) ? longint'(POS_MAX) : p;
  endfunction

  function automatic longint move_component(longint dir, longint unsigned stp);
    longint m;
    m = longint'(step_product(abs_of(dir), stp));
    return dir < 0 ? -m : m;
  endfunction

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit vector in Q16.16; magnitudes are shifted together to fit 31 bits first
  task automatic unit_vector(input longint v[3], output longint u[3]);
    longint unsigned m[3];
    longint unsigned len;
    for (int k = 0; k < 3; k++) m[k] = abs_of(v[k]);
    while (m[0] >= 64'h8000_0000 || m[1] >= 64'h8000_0000 || m[2] >= 64'h8000_0000)
      for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
    len = int_root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int k = 0; k < 3; k++) begin
      if (len == 0) begin
        u[k] = 0;
      end else begin
        u[k] = longint'((m[k] << 16) / len);
        if (v[k] < 0) u[k] = -u[k];
      end
    end
  endtask

  // apply one accepted word to the store and queue the reports it causes
  task automatic update_store(input req_word_t w);
    longint           v[3], nd[3], d[3];
    longint unsigned  stp, el;
    int unsigned      n;
    logic [2:0]       m;
    bit               exp_f;
    particle_report_t r;
    v[0] = longint'($signed(w.vx));
    v[1] = longint'($signed(w.vy));
    v[2] = longint'($signed(w.vz));
    n = count_reg > N_PART ? N_PART : count_reg;
    case (w.req)
      psu_pkg::REQ_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          spawn_pos[w.idx][k] = clamp_pos(v[k]);
          cur_pos[w.idx][k] = spawn_pos[w.idx][k];
        end
        speed_of[w.idx] = w.spd;
        limit_of[w.idx] = w.lim;
        elapsed_of[w.idx] = 0;
      end
      psu_pkg::REQ_RESET: begin
        for (int i = 0; i < n; i++) begin
          for (int k = 0; k < 3; k++) cur_pos[i][k] = spawn_pos[i][k];
          elapsed_of[i] = 0;
        end
      end
      psu_pkg::REQ_TICK: begin
        m = w.mode > psu_pkg::MODE_AGE ? psu_pkg::MODE_AGE : w.mode;
        if (m == psu_pkg::MODE_NORM) unit_vector(v, nd);
        for (int i = 0; i < n; i++) begin
          stp = step_product(speed_of[i], w.dt);
          exp_f = 1'b0;
          if (m == psu_pkg::MODE_FALL) begin
            cur_pos[i][1] = clamp_pos(cur_pos[i][1] - longint'(stp));
          end else if (m == psu_pkg::MODE_RISE) begin
            cur_pos[i][1] = clamp_pos(cur_pos[i][1] + longint'(stp));
          end else if (m != psu_pkg::MODE_AGE) begin
            if (m == psu_pkg::MODE_NORM) begin
              d = nd;
            end else if (m == psu_pkg::MODE_RAW) begin
              d = v;
            end else begin
              // radial: direction from the pivot to the particle
              for (int k = 0; k < 3; k++) nd[k] = cur_pos[i][k] - pivot_reg[k];
              unit_vector(nd, d);
            end
            for (int k = 0; k < 3; k++)
              cur_pos[i][k] = clamp_pos(cur_pos[i][k] + move_component(d[k], stp));
          end
          el = elapsed_of[i] + w.dt;
          if (el > ELAPSED_TOP) el = ELAPSED_TOP;
          elapsed_of[i] = el;
          if (limit_of[i] <= elapsed_of[i]) begin
            if (loop_reg) begin
              if (m == psu_pkg::MODE_FALL || m == psu_pkg::MODE_RISE) begin
                cur_pos[i][1] = spawn_pos[i][1];
              end else begin
                for (int k = 0; k < 3; k++) cur_pos[i][k] = spawn_pos[i][k];
              end
              elapsed_of[i] = 0;
            end else begin
              exp_f = 1'b1;
            end
          end
          r.idx = 6'(i);
          r.x = cur_pos[i][0][31:0];
          r.y = cur_pos[i][1][31:0];
          r.z = cur_pos[i][2][31:0];
          r.el = elapsed_of[i][30:0];
          r.expired = exp_f;
          r.last = (i + 1 == n);
          pending_reports.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  function automatic req_word_t make_word(logic [1:0] req, logic [5:0] idx,
                                          logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                          logic [30:0] spd, logic [30:0] lim,
                                          logic [30:0] dt, logic [2:0] mode);
    req_word_t w;
    w.req = req; w.idx = idx; w.vx = vx; w.vy = vy; w.vz = vz;
    w.spd = spd; w.lim = lim; w.dt = dt; w.mode = mode;
    return w;
  endfunction

  function automatic stim_row_t make_row(req_word_t w, bit typed, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z, logic [30:0] el,
                                         logic expired);
    stim_row_t s;
    s.w = w;
    s.typed = typed;
    s.e.idx = '0; s.e.x = x; s.e.y = y; s.e.z = z;
    s.e.el = el; s.e.expired = expired; s.e.last = 1'b1;
    return s;
  endfunction

  // random word: mostly loads and ticks with a mix of small and full-range values
  function automatic req_word_t random_word();
    req_word_t   w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.req = pick < 35 ? psu_pkg::REQ_LOAD : pick < 82 ? psu_pkg::REQ_TICK :
            pick < 92 ? psu_pkg::REQ_RESET : 2'd3;
    w.idx = 6'($urandom);
    w.vx = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 32'h0040_0000))
           - 32'sh0020_0000;
    w.vy = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 32'h0040_0000))
           - 32'sh0020_0000;
    w.vz = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 32'h0040_0000))
           - 32'sh0020_0000;
    if ($urandom_range(0, 9) == 0) w.vx = '0;
    w.spd = $urandom_range(0, 4) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
    w.lim = $urandom_range(0, 4) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0008_0000));
    w.dt  = $urandom_range(0, 4) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0002_0000));
    w.mode = 3'($urandom);
    return w;
  endfunction

  // drive one word; called and returns at a falling edge
  task automatic send_word(input req_word_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_req_type = w.req;
    in_particle_index = w.idx;
    in_vector_x = w.vx;
    in_vector_y = w.vy;
    in_vector_z = w.vz;
    in_particle_speed = w.spd;
    in_life_limit = w.lim;
    in_time_step = w.dt;
    in_motion_mode = w.mode;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    update_store(w);
    words_sent++;
    if (w.req == psu_pkg::REQ_TICK) ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      psu_pkg::CFG_COUNT:   count_reg = data[6:0];
      psu_pkg::CFG_LOOP:    loop_reg = data[0];
      psu_pkg::CFG_PIVOT_X: pivot_reg[0] = longint'($signed(data));
      psu_pkg::CFG_PIVOT_Y: pivot_reg[1] = longint'($signed(data));
      psu_pkg::CFG_PIVOT_Z: pivot_reg[2] = longint'($signed(data));
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // wait for every report, then let a trailing reset-to-spawn pass before touching registers
  task automatic drain();
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side: random stall bursts, none in the final stretch
  always @(negedge clk) begin
    if (quiet) begin
      out_ready = 1'b1;
    end else if (out_stall_left > 0) begin
      out_ready = 1'b0;
      out_stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready = 1'b0;
      out_stall_left = $urandom_range(0, 10);
    end else begin
      out_ready = 1'b1;
    end
  end

  // compare each accepted report with the oldest prediction; watchdog on handshakes
  always @(posedge clk) begin
    particle_report_t e;
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("unexpected report word: index %0d", out_index);
        errors++;
      end else begin
        e = pending_reports.pop_front();
        if (out_index !== e.idx) begin
          $error("out_index: expected %0d, got %0d", e.idx, out_index); errors++;
        end
        if (out_pos_x !== e.x) begin
          $error("out_pos_x: expected %h, got %h", e.x, out_pos_x); errors++;
        end
        if (out_pos_y !== e.y) begin
          $error("out_pos_y: expected %h, got %h", e.y, out_pos_y); errors++;
        end
        if (out_pos_z !== e.z) begin
          $error("out_pos_z: expected %h, got %h", e.z, out_pos_z); errors++;
        end
        if (out_elapsed_life !== e.el) begin
          $error("out_elapsed_life: expected %h, got %h", e.el, out_elapsed_life); errors++;
        end
        if (out_expired !== e.expired) begin
          $error("out_expired: expected %b, got %b", e.expired, out_expired); errors++;
        end
        if (out_last !== e.last) begin
          $error("out_last: expected %b, got %b", e.last, out_last); errors++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   dir_tab[$];
    stim_row_t   s;
    int          phase_items;
    logic [6:0]  phase_counts[8] = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd5, 7'd16, 7'd3, 7'd8};
    logic [31:0] pv;

    // directed ticks and resets run on particle 0 alone
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_LOAD, 0, 0, 0, 0, 31'h10000, 31'h30000,
                                         0, psu_pkg::MODE_FALL), 0, 0, 0, 0, 0, 0));
    // fall by one unit, then rise back
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 31'h10000,
                                         psu_pkg::MODE_FALL),
                               1, 32'h0, 32'hFFFF_0000, 32'h0, 31'h10000, 1'b0));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 31'h10000,
                                         psu_pkg::MODE_RISE),
                               1, 32'h0, 32'h0, 32'h0, 31'h20000, 1'b0));
    // aging reaches the limit exactly with looping off
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 31'h10000,
                                         psu_pkg::MODE_AGE),
                               1, 32'h0, 32'h0, 32'h0, 31'h30000, 1'b1));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_RESET, 0, 0, 0, 0, 0, 0, 0,
                                         psu_pkg::MODE_AGE), 0, 0, 0, 0, 0, 0));
    // mode seven ages only; zero step after reset to spawn
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 3'd7),
                               1, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                         32'h7FFF_FFFF, '1, '1, 0, psu_pkg::MODE_FALL),
                               0, 0, 0, 0, 0, 0));
    // full speed times full dt saturates the step; elapsed reaches its top value too
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, '1,
                                         psu_pkg::MODE_RISE),
                               1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '1, 1'b1));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                                         32'h8000_0000, 31'h10000, 0, 0, psu_pkg::MODE_FALL),
                               0, 0, 0, 0, 0, 0));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                         0, 0, 0, 31'h10000, psu_pkg::MODE_RAW),
                               0, 0, 0, 0, 0, 0));
    // zero direction normalizes to zero
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 31'h10000,
                                         psu_pkg::MODE_NORM), 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 32'h30000, 32'hFFFC_0000, 0,
                                         0, 0, 31'h20000, psu_pkg::MODE_NORM),
                               0, 0, 0, 0, 0, 0));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 32'h8000_0000, 32'h8000_0000,
                                         32'h8000_0000, 0, 0, 31'h10000, psu_pkg::MODE_NORM),
                               0, 0, 0, 0, 0, 0));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 31'h18000,
                                         psu_pkg::MODE_RADIAL), 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 31'h1000, 3'd6),
                               0, 0, 0, 0, 0, 0));
    // request type three is dropped
    dir_tab.push_back(make_row(make_word(2'd3, 6'd63, '1, '1, '1, '1, '1, '1, 3'd7),
                               0, 0, 0, 0, 0, 0));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_LOAD, 6'd63, 32'h1234_5678,
                                         32'h8765_4321, 32'h0, '1, 31'h40000, 0,
                                         psu_pkg::MODE_FALL), 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(make_row(make_word(psu_pkg::REQ_TICK, 0, 32'hFFFF_FFFF, 32'h1,
                                         32'h7FFF_FFFF, 0, 0, 31'h30000, psu_pkg::MODE_RAW),
                               0, 0, 0, 0, 0, 0));

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed part on a single particle
    write_reg(psu_pkg::CFG_COUNT, 32'd1);
    foreach (dir_tab[i]) begin
      s = dir_tab[i];
      send_word(s.w);
      if (s.typed) begin
        void'(pending_reports.pop_back());
        pending_reports.push_back(s.e);
      end
    end
    drain();

    // fill every slot before anything can read the whole store
    for (int i = 0; i < N_PART; i++) begin
      req_word_t w;
      w = random_word();
      w.req = psu_pkg::REQ_LOAD;
      w.idx = 6'(i);
      send_word(w);
    end
    drain();

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1'b1;
      write_reg(psu_pkg::CFG_COUNT, ph == 7 ? 32'd64 : {25'($urandom), phase_counts[ph]});
      write_reg(psu_pkg::CFG_LOOP, {31'($urandom), ph[0]});
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 3))
          0: pv = 32'h7FFF_FFFF;
          1: pv = 32'h8000_0000;
          2: pv = $urandom;
          default: pv = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
        write_reg(3'(psu_pkg::CFG_PIVOT_X + k), pv);
      end
      phase_items = 0;
      while (phase_items < PHASE_WORDS) begin
        req_word_t w;
        w = random_word();
        send_word(w);
        if (w.req != 2'd3) phase_items++;
      end
      drain();
    end

    $display("covered %0d request words, %0d ticks, %0d particle reports checked",
             words_sent, ticks_sent, reports_seen);
    $display("register settings: counts 0, 1, 64 and above range, loop on and off, pivot extremes");
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/psu_pkg.sv
sv/psu_ram.sv
sv/psu_norm.sv
sv/particle_store_update.sv
sim/particle_store_update_tb.sv
